@@ rtl/lookahead_peak_limiter_assert.svh @@
// Assertion macros for the lookahead peak limiter.
// Expects clk and rst_n in the scope where the macros are used.
`ifndef LOOKAHEAD_PEAK_LIMITER_ASSERT_SVH
`define LOOKAHEAD_PEAK_LIMITER_ASSERT_SVH

// condition holds at every clock edge outside reset
`define LPL_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define LPL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/lpl_pkg.sv @@
// Package for the lookahead peak limiter: sequencer states, register map, constants.
// No dependencies.
package lpl_pkg;

    // register indexes on the APB port (byte address = 4 * index)
    localparam logic [2:0] REG_INPUT_GAIN   = 3'd0;
    localparam logic [2:0] REG_CEILING      = 3'd1;
    localparam logic [2:0] REG_ATTACK_COEF  = 3'd2;
    localparam logic [2:0] REG_RELEASE_COEF = 3'd3;
    localparam logic [2:0] REG_LOOKAHEAD    = 3'd4;
    localparam logic [2:0] REG_ACTIVE_CH    = 3'd5;

    // register reset values
    localparam logic [20:0] RST_INPUT_GAIN   = 21'd65536;
    localparam logic [16:0] RST_CEILING      = 17'd63311;
    localparam logic [23:0] RST_ATTACK_COEF  = 24'd345936;
    localparam logic [23:0] RST_RELEASE_COEF = 24'd2330;
    localparam logic [8:0]  RST_LOOKAHEAD    = 9'd240;
    localparam logic [1:0]  RST_ACTIVE_CH    = 2'd2;

    // unity gain in Q1.24
    localparam logic [24:0] UNITY_GAIN = 25'h1000000;

    // restoring divider: one quotient bit per cycle, 24 bits
    localparam logic [4:0] DIV_LAST = 5'd23;

    // sequencer states, one-hot
    typedef enum logic [17:0] {
        S_CLEAR      = 18'b000000000000000001,
        S_IDLE       = 18'b000000000000000010,
        S_MUL_L      = 18'b000000000000000100,
        S_SC_L       = 18'b000000000000001000,
        S_SC_R       = 18'b000000000000010000,
        S_DIV        = 18'b000000000000100000,
        S_POPF_RD    = 18'b000000000001000000,
        S_POPF_CMP   = 18'b000000000010000000,
        S_POPB_RD    = 18'b000000000100000000,
        S_POPB_CMP   = 18'b000000001000000000,
        S_PUSH       = 18'b000000010000000000,
        S_TGT_RD     = 18'b000000100000000000,
        S_SMOOTH     = 18'b000001000000000000,
        S_SMOOTH_UPD = 18'b000010000000000000,
        S_OUT_L      = 18'b000100000000000000,
        S_OUT_R      = 18'b001000000000000000,
        S_OUT_FIN    = 18'b010000000000000000,
        S_RESULT     = 18'b100000000000000000
    } state_t;

endpackage

@@ rtl/lookahead_peak_limiter.sv @@
// Lookahead peak limiter top level: sequencer, shared multiplier, divider, delay and deque RAMs.
// Depends on lpl_pkg and lookahead_peak_limiter_assert.svh.
//
//  channel | dir | payload                                   | beat
//  s_*     | in  | tdata 48b: sample_left, sample_right      | s_tvalid & s_tready
//  m_*     | out | tdata 80b: out_left, out_right, gain_now  | m_tvalid & m_tready
//  apb     | in  | six registers at 4*i, 32-bit data         | psel & penable & pwrite
//
// Each frame walks the sequencer states from input beat to output beat; every deque entry
// read adds a read and a compare state, and a peak above the ceiling adds the bit-serial
// divider. All products go through one 30x26 multiplier.
// After reset and after each lookahead_length write, a clearing pass over all MAX_LOOKAHEAD+1
// entries zeroes the delay RAMs; s_tready stays low meanwhile.
// One frame is in flight at a time; a stalled output beat holds the block.
`include "lookahead_peak_limiter_assert.svh"

module lookahead_peak_limiter #(
    parameter int MAX_LOOKAHEAD = 256,
    parameter int CHANNELS      = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    // stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [23:0] sample_left, [47:24] sample_right
    // stream out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [23:0] out_left, [47:24] out_right, [72:48] gain_now
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lpl_pkg::*;

    localparam int PW     = $clog2(MAX_LOOKAHEAD + 1);
    localparam bit TWO_CH = (CHANNELS > 1);

    // configuration registers
    logic [20:0] input_gain_reg;
    logic [16:0] ceiling_reg;
    logic [23:0] attack_reg;
    logic [23:0] release_reg;
    logic [8:0]  look_reg;
    logic [1:0]  chan_reg;

    // control state
    state_t         state_reg, state_next;
    logic [PW-1:0]  clr_idx_reg, clr_idx_next;
    logic [PW-1:0]  wp_reg, wp_next;
    logic [PW-1:0]  head_reg, head_next;
    logic [PW-1:0]  tail_reg, tail_next;
    logic [15:0]    sp_reg, sp_next;
    logic [24:0]    g_reg, g_next;
    logic [4:0]     cnt_reg, cnt_next;

    // datapath registers
    logic [23:0]        sl_reg, sl_next;
    logic [23:0]        sr_reg, sr_next;
    logic signed [28:0] xl_reg, xl_next;
    logic [27:0]        peak_reg, peak_next;
    logic [28:0]        r_reg, r_next;
    logic [23:0]        q_reg, q_next;
    logic [24:0]        wanted_reg, wanted_next;
    logic               dneg_reg, dneg_next;
    logic [23:0]        out_l_reg, out_l_next;
    logic [23:0]        out_r_reg, out_r_next;
    logic signed [55:0] mul_p_reg;

    // memories
    logic signed [28:0] dl_mem [0:MAX_LOOKAHEAD];
    logic signed [28:0] dr_mem [0:MAX_LOOKAHEAD];
    logic [24:0]        wg_mem [0:MAX_LOOKAHEAD];
    logic [15:0]        wpos_mem [0:MAX_LOOKAHEAD];
    logic signed [28:0] dl_q_reg, dr_q_reg;
    logic [24:0]        wg_q_reg;
    logic [15:0]        wpos_q_reg;

    logic               dl_we, dr_we, d_re;
    logic [PW-1:0]      d_waddr, d_raddr;
    logic signed [28:0] dl_wdata, dr_wdata;
    logic               win_we, win_re;
    logic [PW-1:0]      win_raddr;

    // multiplier operands
    logic signed [29:0] mul_a;
    logic signed [25:0] mul_b;

    logic [PW-1:0] eff_len;
    logic          two_act;
    logic [23:0]   ceil23;
    logic          cfg_wr;

    // rounding of the shared product
    logic          p_neg;
    logic [55:0]   p_mag;
    logic [27:0]   r16_mag;
    logic [28:0]   r16_val;
    logic [29:0]   r24_mag;
    logic [24:0]   sm_mag;
    logic [23:0]   clamp_mag;
    logic [23:0]   y_val;

    // smoother operands
    logic          s_dneg;
    logic [24:0]   s_absd;
    logic [23:0]   s_coef;

    // divider step
    logic [29:0]   div_r2;
    logic          div_ge;

    logic [15:0]   win_age;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p, input logic [PW-1:0] l);
        return (p == l) ? '0 : p + PW'(1);
    endfunction

    function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p, input logic [PW-1:0] l);
        return (p == '0) ? l : p - PW'(1);
    endfunction

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign ceil23 = {ceiling_reg, 7'b0};
    assign two_act = TWO_CH && (chan_reg >= 2'd2);

    // effective lookahead: 0 acts as 1, clamp to MAX_LOOKAHEAD
    always_comb
    begin
        if (look_reg == '0)
            eff_len = PW'(1);
        else if (32'(look_reg) > 32'(MAX_LOOKAHEAD))
            eff_len = PW'(MAX_LOOKAHEAD);
        else
            eff_len = PW'(look_reg);
    end

    // register readback
    always_comb
    begin
        case (paddr[4:2])
            REG_INPUT_GAIN:   prdata = {11'b0, input_gain_reg};
            REG_CEILING:      prdata = {15'b0, ceiling_reg};
            REG_ATTACK_COEF:  prdata = {8'b0, attack_reg};
            REG_RELEASE_COEF: prdata = {8'b0, release_reg};
            REG_LOOKAHEAD:    prdata = {23'b0, look_reg};
            REG_ACTIVE_CH:    prdata = {30'b0, chan_reg};
            default:          prdata = 32'b0;
        endcase
    end

    // product magnitude and its roundings
    always_comb
    begin
        p_neg   = mul_p_reg[55];
        p_mag   = p_neg ? 56'(-mul_p_reg) : 56'(mul_p_reg);
        r16_mag = 28'((p_mag + 56'd32768) >> 16);
        r16_val = p_neg ? 29'(-{1'b0, r16_mag}) : {1'b0, r16_mag};
        r24_mag = 30'((p_mag + 56'd8388608) >> 24);
        sm_mag  = 25'((p_mag + 56'hFFFFFF) >> 24);
        // clamp to ceiling, then saturate the positive side
        clamp_mag = (r24_mag > 30'(ceil23)) ? ceil23 : r24_mag[23:0];
        if (!p_neg && clamp_mag == 24'h800000)
            clamp_mag = 24'h7FFFFF;
        y_val = p_neg ? 24'(-clamp_mag) : clamp_mag;
    end

    // smoother direction and step operands
    always_comb
    begin
        s_dneg = wg_q_reg < g_reg;
        s_absd = s_dneg ? (g_reg - wg_q_reg) : (wg_q_reg - g_reg);
        s_coef = s_dneg ? attack_reg : release_reg;
    end

    assign div_r2  = {r_reg, 1'b0};
    assign div_ge  = div_r2 >= {2'b0, peak_reg};
    assign win_age = sp_reg - wpos_q_reg;

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MUL_L:
            begin
                mul_a = 30'(signed'(sl_reg));
                mul_b = signed'({5'b0, input_gain_reg});
            end
            S_SC_L:
            begin
                mul_a = 30'(signed'(sr_reg));
                mul_b = signed'({5'b0, input_gain_reg});
            end
            S_SMOOTH:
            begin
                mul_a = signed'({5'b0, s_absd});
                mul_b = signed'({2'b0, s_coef});
            end
            S_OUT_L:
            begin
                mul_a = 30'(dl_q_reg);
                mul_b = signed'({1'b0, g_reg});
            end
            S_OUT_R:
            begin
                mul_a = 30'(dr_q_reg);
                mul_b = signed'({1'b0, g_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        wp_next      = wp_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        sp_next      = sp_reg;
        g_next       = g_reg;
        cnt_next     = cnt_reg;
        sl_next      = sl_reg;
        sr_next      = sr_reg;
        xl_next      = xl_reg;
        peak_next    = peak_reg;
        r_next       = r_reg;
        q_next       = q_reg;
        wanted_next  = wanted_reg;
        dneg_next    = dneg_reg;
        out_l_next   = out_l_reg;
        out_r_next   = out_r_reg;
        dl_we        = 1'b0;
        dr_we        = 1'b0;
        d_waddr      = wp_reg;
        dl_wdata     = xl_reg;
        dr_wdata     = 29'(signed'(r16_val));
        d_re         = 1'b0;
        d_raddr      = ptr_inc(wp_reg, eff_len);
        win_we       = 1'b0;
        win_re       = 1'b0;
        win_raddr    = head_reg;

        case (state_reg)
            S_CLEAR:
            begin
                dl_we    = 1'b1;
                dr_we    = 1'b1;
                d_waddr  = clr_idx_reg;
                dl_wdata = '0;
                dr_wdata = '0;
                clr_idx_next = clr_idx_reg + PW'(1);
                if (clr_idx_reg == PW'(MAX_LOOKAHEAD))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    sl_next = s_tdata[23:0];
                    sr_next = s_tdata[47:24];
                    if (chan_reg == 2'd0)
                    begin
                        out_l_next = '0;
                        out_r_next = '0;
                        state_next = S_RESULT;
                    end
                    else
                        state_next = S_MUL_L;
                end
            end
            S_MUL_L:
                state_next = S_SC_L;
            S_SC_L:
            begin
                xl_next    = signed'(r16_val);
                peak_next  = r16_mag;
                state_next = S_SC_R;
            end
            S_SC_R:
            begin
                // store scaled frame, finish peak, pick divide or unity
                dl_we = 1'b1;
                dr_we = two_act;
                if (two_act && r16_mag > peak_reg)
                    peak_next = r16_mag;
                if (peak_next > {4'b0, ceil23})
                begin
                    r_next     = 29'(ceil23);
                    q_next     = '0;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
                else
                begin
                    wanted_next = UNITY_GAIN;
                    state_next  = S_POPF_RD;
                end
            end
            S_DIV:
            begin
                r_next   = div_ge ? 29'(div_r2 - {2'b0, peak_reg}) : div_r2[28:0];
                q_next   = {q_reg[22:0], div_ge};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == DIV_LAST)
                begin
                    wanted_next = {1'b0, q_next};
                    state_next  = S_POPF_RD;
                end
            end
            S_POPF_RD:
            begin
                // drop expired entries from the deque front
                if (head_reg == tail_reg)
                    state_next = S_POPB_RD;
                else
                begin
                    win_re     = 1'b1;
                    win_raddr  = head_reg;
                    state_next = S_POPF_CMP;
                end
            end
            S_POPF_CMP:
            begin
                if (32'(win_age) >= 32'(eff_len))
                begin
                    head_next  = ptr_inc(head_reg, eff_len);
                    state_next = S_POPF_RD;
                end
                else
                    state_next = S_POPB_RD;
            end
            S_POPB_RD:
            begin
                // drop back entries not below the new gain
                if (tail_reg == head_reg)
                    state_next = S_PUSH;
                else
                begin
                    win_re     = 1'b1;
                    win_raddr  = ptr_dec(tail_reg, eff_len);
                    state_next = S_POPB_CMP;
                end
            end
            S_POPB_CMP:
            begin
                if (wg_q_reg < wanted_reg)
                    state_next = S_PUSH;
                else
                begin
                    tail_next  = ptr_dec(tail_reg, eff_len);
                    state_next = S_POPB_RD;
                end
            end
            S_PUSH:
            begin
                win_we     = 1'b1;
                tail_next  = ptr_inc(tail_reg, eff_len);
                sp_next    = sp_reg + 16'd1;
                state_next = S_TGT_RD;
            end
            S_TGT_RD:
            begin
                win_re     = 1'b1;
                win_raddr  = head_reg;
                state_next = S_SMOOTH;
            end
            S_SMOOTH:
            begin
                // target is in wg_q_reg; fetch the delayed frame
                dneg_next  = s_dneg;
                d_re       = 1'b1;
                state_next = S_SMOOTH_UPD;
            end
            S_SMOOTH_UPD:
            begin
                g_next     = dneg_reg ? (g_reg - sm_mag) : (g_reg + sm_mag);
                state_next = S_OUT_L;
            end
            S_OUT_L:
                state_next = S_OUT_R;
            S_OUT_R:
            begin
                out_l_next = y_val;
                state_next = S_OUT_FIN;
            end
            S_OUT_FIN:
            begin
                out_r_next = two_act ? y_val : '0;
                wp_next    = ptr_inc(wp_reg, eff_len);
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (m_tready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase

        // lookahead write restarts state and the clearing pass
        if (cfg_wr && paddr[4:2] == REG_LOOKAHEAD)
        begin
            state_next   = S_CLEAR;
            clr_idx_next = '0;
            wp_next      = '0;
            head_next    = '0;
            tail_next    = '0;
            sp_next      = '0;
            g_next       = UNITY_GAIN;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_RESULT);
    assign m_tdata  = {7'b0, g_reg, out_r_reg, out_l_reg};

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_gain_reg <= RST_INPUT_GAIN;
            ceiling_reg    <= RST_CEILING;
            attack_reg     <= RST_ATTACK_COEF;
            release_reg    <= RST_RELEASE_COEF;
            look_reg       <= RST_LOOKAHEAD;
            chan_reg       <= RST_ACTIVE_CH;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                REG_INPUT_GAIN:   input_gain_reg <= pwdata[20:0];
                REG_CEILING:      ceiling_reg    <= pwdata[16:0];
                REG_ATTACK_COEF:  attack_reg     <= pwdata[23:0];
                REG_RELEASE_COEF: release_reg    <= pwdata[23:0];
                REG_LOOKAHEAD:    look_reg       <= pwdata[8:0];
                REG_ACTIVE_CH:    chan_reg       <= pwdata[1:0];
                default:          ;
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_idx_reg <= '0;
            wp_reg      <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            sp_reg      <= '0;
            g_reg       <= UNITY_GAIN;
            cnt_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            wp_reg      <= wp_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            sp_reg      <= sp_next;
            g_reg       <= g_next;
            cnt_reg     <= cnt_next;
        end
    end

    // datapath registers and shared multiplier
    always_ff @(posedge clk)
    begin
        sl_reg     <= sl_next;
        sr_reg     <= sr_next;
        xl_reg     <= xl_next;
        peak_reg   <= peak_next;
        r_reg      <= r_next;
        q_reg      <= q_next;
        wanted_reg <= wanted_next;
        dneg_reg   <= dneg_next;
        out_l_reg  <= out_l_next;
        out_r_reg  <= out_r_next;
        mul_p_reg  <= 56'(mul_a * mul_b);
    end

    // delay line RAMs
    always_ff @(posedge clk)
    begin
        if (dl_we)
            dl_mem[d_waddr] <= dl_wdata;
        if (dr_we)
            dr_mem[d_waddr] <= dr_wdata;
        if (d_re)
        begin
            dl_q_reg <= dl_mem[d_raddr];
            dr_q_reg <= dr_mem[d_raddr];
        end
    end

    // deque RAMs
    always_ff @(posedge clk)
    begin
        if (win_we)
        begin
            wg_mem[tail_reg]   <= wanted_reg;
            wpos_mem[tail_reg] <= sp_reg;
        end
        if (win_re)
        begin
            wg_q_reg   <= wg_mem[win_raddr];
            wpos_q_reg <= wpos_mem[win_raddr];
        end
    end

    `LPL_ASSERT_ALWAYS(a_one_frame, !(s_tready && m_tvalid), "ready while result pending")
    `LPL_ASSERT_ALWAYS(a_gain_range, g_reg <= UNITY_GAIN, "smoothed gain above unity")
    `LPL_ASSERT_NEXT(a_div_hold, (state_reg == S_DIV) && (cnt_reg != DIV_LAST), state_reg == S_DIV, "divider left early")
    `LPL_ASSERT_NEXT(a_beat_idle, m_tvalid && m_tready, state_reg == S_IDLE, "no return to idle after beat")

endmodule

@@ sim/lookahead_peak_limiter_test.sv @@
// Self-checking testbench for the lookahead peak limiter: streams sample frames,
// predicts each limited frame and gain, and compares. Depends on lpl_pkg and the RTL.
`timescale 1ns / 1ps

module lookahead_peak_limiter_test;
    import lpl_pkg::*;

    // packed from the top bit down, so out_left lands in the lowest bits
    typedef struct packed {
        logic [24:0] gain_now;
        logic [23:0] out_right;
        logic [23:0] out_left;
    } frame_out_t;

    localparam int MAXLA = 256;
    localparam int CAPD  = MAXLA + 1;
    localparam int WATCHDOG_LIMIT = 200000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    lookahead_peak_limiter dut (.*);

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // predictor copy of registers and state
    longint cfg_in_gain, cfg_ceiling, cfg_attack, cfg_release, cfg_la, cfg_nch;
    longint dly_l [CAPD];
    longint dly_r [CAPD];
    longint win_gain [CAPD];
    int     win_pos [CAPD];
    int     dly_wp, win_head, win_tail, samp_pos;
    longint gain_state;

    frame_out_t expected_frames[$];
    int     error_count;
    int     frames_sent;
    int     frames_checked;
    int     quiet_cycles;
    bit     no_idle;

    function automatic void clear_predictor();
        for (int i = 0; i < CAPD; i++)
        begin
            dly_l[i] = 0;
            dly_r[i] = 0;
            win_gain[i] = 0;
            win_pos[i] = 0;
        end
        dly_wp = 0;
        win_head = 0;
        win_tail = 0;
        samp_pos = 0;
        gain_state = 64'd16777216;
    endfunction

    function automatic longint round_shr(longint p, int s);
        longint m;
        m = p < 0 ? -p : p;
        m = (m + (longint'(1) << (s - 1))) >>> s;
        return p < 0 ? -m : m;
    endfunction

    // sliding minimum of wanted gains over the window
    function automatic longint window_min(longint value, int len);
        int cap;
        int back;
        cap = len + 1;
        if (win_head >= cap) win_head = 0;
        if (win_tail >= cap) win_tail = 0;
        while (win_head != win_tail && ((samp_pos - win_pos[win_head]) & 16'hFFFF) >= len)
            win_head = (win_head + 1) % cap;
        while (win_tail != win_head)
        begin
            back = (win_tail + cap - 1) % cap;
            if (win_gain[back] < value) break;
            win_tail = back;
        end
        win_gain[win_tail] = value;
        win_pos[win_tail] = samp_pos;
        win_tail = (win_tail + 1) % cap;
        samp_pos = (samp_pos + 1) & 16'hFFFF;
        return win_gain[win_head];
    endfunction

    function automatic frame_out_t limit_frame(logic [23:0] left, logic [23:0] right);
        frame_out_t r;
        int len, dlen, nch, rd;
        longint x [2];
        longint ceil23, peak, wanted, target, diff, coef, mag, v, d, a;
        len = cfg_la < 1 ? 1 : (cfg_la > MAXLA ? MAXLA : int'(cfg_la));
        dlen = len + 1;
        nch = cfg_nch > 2 ? 2 : int'(cfg_nch);
        ceil23 = cfg_ceiling << 7;
        r = '0;
        if (nch == 0)
        begin
            r.gain_now = gain_state[24:0];
            return r;
        end
        if (dly_wp >= dlen) dly_wp = 0;
        peak = 0;
        for (int c = 0; c < nch; c++)
        begin
            v = round_shr(longint'($signed(c == 0 ? left : right)) * cfg_in_gain, 16);
            a = v < 0 ? -v : v;
            x[c] = v;
            if (a > peak) peak = a;
        end
        dly_l[dly_wp] = x[0];
        if (nch > 1) dly_r[dly_wp] = x[1];
        wanted = peak > ceil23 ? (ceil23 << 24) / peak : 64'd16777216;
        target = window_min(wanted, len);
        diff = target - gain_state;
        coef = target < gain_state ? cfg_attack : cfg_release;
        mag = ((diff < 0 ? -diff : diff) * coef + 64'hFFFFFF) >>> 24;
        gain_state += diff < 0 ? -mag : mag;
        rd = (dly_wp + 1) % dlen;
        for (int c = 0; c < nch; c++)
        begin
            d = c == 0 ? dly_l[rd] : dly_r[rd];
            v = round_shr(d * gain_state, 24);
            if (v > ceil23) v = ceil23;
            if (v < -ceil23) v = -ceil23;
            if (v > 8388607) v = 8388607;
            if (v < -8388608) v = -8388608;
            if (c == 0) r.out_left = v[23:0];
            else r.out_right = v[23:0];
        end
        dly_wp = rd;
        r.gain_now = gain_state[24:0];
        return r;
    endfunction

    function automatic bit idle_now();
        return !no_idle && ($urandom_range(99) < 17);
    endfunction

    // register write over APB, only once no frame is in flight
    task automatic write_reg(logic [2:0] idx, longint value);
        s_tvalid <= 1'b0;
        while (expected_frames.size() != 0) @(posedge clk);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value[31:0];
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_INPUT_GAIN:   cfg_in_gain = value & 21'h1FFFFF;
            REG_CEILING:      cfg_ceiling = value & 17'h1FFFF;
            REG_ATTACK_COEF:  cfg_attack  = value & 24'hFFFFFF;
            REG_RELEASE_COEF: cfg_release = value & 24'hFFFFFF;
            REG_LOOKAHEAD:
            begin
                cfg_la = value & 9'h1FF;
                clear_predictor();
            end
            REG_ACTIVE_CH:    cfg_nch = value & 2'h3;
            default: ;
        endcase
    endtask

    // one input beat; valid stays high across back-to-back beats
    task automatic send_frame(logic [23:0] left, logic [23:0] right);
        while (idle_now())
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {right, left};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        expected_frames.push_back(limit_frame(left, right));
        frames_sent++;
    endtask

    task automatic drain();
        @(posedge clk);
        s_tvalid <= 1'b0;
        while (expected_frames.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    function automatic logic [23:0] rand_sample();
        case ($urandom_range(4))
            0: return 24'h7FFFFF - 24'($urandom_range(3));
            1: return 24'h800000 + 24'($urandom_range(3));
            2: return 24'($signed($urandom_range(4000)) - 2000);
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic random_frames(int n);
        for (int i = 0; i < n; i++)
            send_frame(rand_sample(), rand_sample());
    endtask

    // result checker
    always @(posedge clk)
    begin
        frame_out_t got, want;
        if (rst_n)
        begin
            m_tready <= !idle_now();
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[72:0];
                if (expected_frames.size() == 0)
                begin
                    $error("unexpected output beat %h", m_tdata);
                    error_count++;
                end
                else
                begin
                    want = expected_frames.pop_front();
                    if (got.out_left !== want.out_left)
                    begin
                        $error("out_left expected %h actual %h", want.out_left, got.out_left);
                        error_count++;
                    end
                    if (got.out_right !== want.out_right)
                    begin
                        $error("out_right expected %h actual %h", want.out_right, got.out_right);
                        error_count++;
                    end
                    if (got.gain_now !== want.gain_now)
                    begin
                        $error("gain_now expected %h actual %h", want.gain_now, got.gain_now);
                        error_count++;
                    end
                end
                frames_checked++;
            end
        end
    end

    // watchdog on handshake inactivity
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("lookahead_peak_limiter_test failed");
            $finish;
        end
    end

    task automatic test_defaults();
        send_frame(24'h000000, 24'h000000);
        send_frame(24'h7FFFFF, 24'h800000);
        send_frame(24'h800000, 24'h7FFFFF);
        send_frame(24'h000001, 24'hFFFFFF);
        send_frame(24'h400000, 24'hC00000);
        drain();
    endtask

    task automatic test_extremes();
        // short window, hot input, fast attack, slow release
        write_reg(REG_LOOKAHEAD, 1);
        write_reg(REG_INPUT_GAIN, 1048576);
        write_reg(REG_CEILING, 16384);
        write_reg(REG_ATTACK_COEF, 16777215);
        write_reg(REG_RELEASE_COEF, 1);
        send_frame(24'h7FFFFF, 24'h800000);
        send_frame(24'h800000, 24'h000000);
        send_frame(24'h000000, 24'h000000);
        drain();
        // ceiling zero, one channel, no channel, then channel count three
        write_reg(REG_CEILING, 0);
        write_reg(REG_ACTIVE_CH, 1);
        send_frame(24'h000010, 24'h7FFFFF);
        send_frame(24'h000000, 24'h7FFFFF);
        write_reg(REG_ACTIVE_CH, 0);
        send_frame(24'h123456, 24'h654321);
        write_reg(REG_ACTIVE_CH, 3);
        send_frame(24'h7FFFFF, 24'h7FFFFF);
        drain();
        // window length zero and beyond maximum
        write_reg(REG_LOOKAHEAD, 0);
        write_reg(REG_CEILING, 65536);
        write_reg(REG_INPUT_GAIN, 16384);
        send_frame(24'h7FFFFF, 24'h800000);
        send_frame(24'h100000, 24'h100000);
        write_reg(REG_LOOKAHEAD, 511);
        write_reg(REG_ACTIVE_CH, 2);
        write_reg(REG_RELEASE_COEF, 16777215);
        write_reg(REG_ATTACK_COEF, 1);
        send_frame(24'h7FFFFF, 24'h800000);
        send_frame(24'h000000, 24'h000000);
        drain();
    endtask

    task automatic test_random_settings();
        for (int phase = 0; phase < 10; phase++)
        begin
            no_idle = (phase == 4);
            write_reg(REG_INPUT_GAIN, $urandom_range(1048576, 16384));
            write_reg(REG_CEILING, $urandom_range(65536, 16384));
            write_reg(REG_ATTACK_COEF, $urandom_range(16777215, 1));
            write_reg(REG_RELEASE_COEF, $urandom_range(16777215, 1));
            write_reg(REG_LOOKAHEAD, phase < 7 ? $urandom_range(16, 1) : $urandom_range(256, 1));
            write_reg(REG_ACTIVE_CH, $urandom_range(2, 1));
            random_frames(200);
            drain();
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        error_count = 0;
        frames_sent = 0;
        frames_checked = 0;
        quiet_cycles = 0;
        no_idle = 1'b0;
        cfg_in_gain = RST_INPUT_GAIN;
        cfg_ceiling = RST_CEILING;
        cfg_attack  = RST_ATTACK_COEF;
        cfg_release = RST_RELEASE_COEF;
        cfg_la      = RST_LOOKAHEAD;
        cfg_nch     = RST_ACTIVE_CH;
        clear_predictor();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        test_defaults();
        test_extremes();
        test_random_settings();
        $display("covered %0d frames sent, %0d results checked", frames_sent, frames_checked);
        $display("settings swept over gain, ceiling, coefficients, window and channel count");
        if (error_count == 0 && expected_frames.size() == 0)
            $display("lookahead_peak_limiter_test passed");
        else
            $display("lookahead_peak_limiter_test failed");
        $finish;
    end

endmodule
